// ----- hw/rtl/adts_frame_deframer_assert.svh -----
// Assertion helpers shared by the deframer RTL.
// Each macro expects clk_i to be visible where it is used; ADTS_ASSERT also needs rst_ni.
`ifndef ADTS_FRAME_DEFRAMER_ASSERT_SVH
`define ADTS_FRAME_DEFRAMER_ASSERT_SVH

// Checked on every rising edge outside of reset.
`define ADTS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Checked on every rising edge, reset included.
`define ADTS_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

// ----- hw/rtl/adts_pkg.sv -----
package adts_pkg;

  // Result kinds
  typedef enum logic [2:0] {
    OUT_HEADER    = 3'd0,
    OUT_PAYLOAD   = 3'd1,
    OUT_SYNC_LOST = 3'd2,
    OUT_LEN_ERR   = 3'd3,
    OUT_TRUNC     = 3'd4
  } out_kind_e;

  // Parser phase, one-hot
  typedef enum logic [3:0] {
    PH_HUNT    = 4'b0001,
    PH_SYNC2   = 4'b0010,
    PH_HEADER  = 4'b0100,
    PH_PAYLOAD = 4'b1000
  } phase_e;

  // Input beat kinds
  localparam logic KIND_BYTE  = 1'b0;
  localparam logic KIND_FLUSH = 1'b1;

  // Configuration register indexes
  localparam logic CFG_START_TIME = 1'b0;
  localparam logic CFG_TRACK      = 1'b1;

  // Sync pattern
  localparam logic [7:0] SYNC_BYTE   = 8'hFF;
  localparam logic [3:0] SYNC_NIBBLE = 4'hF;

  // Header sizes with and without CRC
  localparam logic [3:0] HDR_SIZE_NO_CRC = 4'd7;
  localparam logic [3:0] HDR_SIZE_CRC    = 4'd9;

  // Result record held in the output register
  typedef struct packed {
    out_kind_e    kind;
    logic [7:0]   payload_byte;
    logic         last;
    logic [1:0]   profile;
    logic [3:0]   rate_index;
    logic [2:0]   channels;
    logic         config_changed;
    logic [15:0]  audio_config;
    logic [31:0]  timestamp_ms;
    logic [12:0]  payload_length;
    logic [7:0]   track;
  } res_t;

  // Frame duration in ms, 1024 samples rounded, per sampling rate index
  function automatic logic [7:0] frame_step_ms(input logic [3:0] rate);
    logic [7:0] step;
    unique case (rate)
      4'd0:    step = 8'd11;
      4'd1:    step = 8'd12;
      4'd2:    step = 8'd16;
      4'd3:    step = 8'd21;
      4'd4:    step = 8'd23;
      4'd5:    step = 8'd32;
      4'd6:    step = 8'd43;
      4'd7:    step = 8'd46;
      4'd8:    step = 8'd64;
      4'd9:    step = 8'd85;
      4'd10:   step = 8'd93;
      4'd11:   step = 8'd128;
      4'd12:   step = 8'd139;
      default: step = 8'd0;
    endcase
    return step;
  endfunction

endpackage

// ----- hw/rtl/adts_frame_deframer.sv -----
// ADTS deframer: takes one stream byte (or a flush) per beat and returns at most one
// result per beat: a header record, a payload byte, or a sync-lost, length-error or
// truncated-frame notice. Each accepted beat is decoded in the cycle it is taken and
// its result lands in the output register on that edge, so the block sustains one
// beat per clock; the only back pressure is a held output register whose result is
// stalled. The header fields are taken from the 5 stored header bytes, the CRC bytes
// are skipped, and each frame's timestamp advances by a per-rate millisecond step.
// Writing start_time_ms reloads the running frame time; write registers only while
// the block is idle.
`include "adts_frame_deframer_assert.svh"

module adts_frame_deframer (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input stream
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        kind_i,
  input  logic [7:0]  data_byte_i,
  // results
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  out_kind_o,
  output logic [7:0]  payload_byte_o,
  output logic        last_o,
  output logic [1:0]  profile_o,
  output logic [3:0]  rate_index_o,
  output logic [2:0]  channels_o,
  output logic        config_changed_o,
  output logic [15:0] audio_config_o,
  output logic [31:0] timestamp_ms_o,
  output logic [12:0] payload_length_o,
  output logic [7:0]  track_o,
  // register writes
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_index_i,
  input  logic [31:0] cfg_data_i
);

  // State
  adts_pkg::phase_e phase_q, phase_d;
  logic [7:0]       hb_q [5];
  logic [7:0]       hb_d [5];
  logic [3:0]       count_q, count_d;
  logic [12:0]      rem_q, rem_d;
  logic             serr_q, serr_d;
  logic             ivalid_q, ivalid_d;
  logic [8:0]       sinfo_q, sinfo_d;
  logic [31:0]      ftime_q, ftime_d;
  logic [7:0]       track_q;

  // Output register
  logic             out_valid_q, out_valid_d;
  adts_pkg::res_t   res_q, res_d;

  // Decode scratch
  logic             in_fire;
  logic             hunt;
  logic             hb_wr;
  logic [2:0]       hb_idx;
  logic [3:0]       hsize;
  logic [12:0]      flen;
  logic [12:0]      plen;
  logic [1:0]       prof;
  logic [3:0]       rate;
  logic [2:0]       ch;
  logic [8:0]       info;
  logic [2:0]       obj_type;

  assign in_stall_o  = out_valid_q & out_stall_i;
  assign in_fire     = in_valid_i & ~in_stall_o;
  assign cfg_ready_o = 1'b1;

  // Header field extraction from the stored (or just written) header bytes
  always_comb begin
    hb_wr  = (phase_q == adts_pkg::PH_HEADER) && (count_q >= 4'd1) && (count_q <= 4'd5);
    hb_idx = 3'(count_q - 4'd1);
    for (int i = 0; i < 5; i++) begin
      hb_d[i] = hb_q[i];
      if (hb_wr && hb_idx == 3'(i)) begin
        hb_d[i] = data_byte_i;
      end
    end
    if (phase_q == adts_pkg::PH_SYNC2) begin
      hb_d[0] = data_byte_i;
    end
    hsize    = hb_d[0][0] ? adts_pkg::HDR_SIZE_NO_CRC : adts_pkg::HDR_SIZE_CRC;
    flen     = {hb_d[2][1:0], hb_d[3], hb_d[4][7:5]};
    plen     = flen - {9'd0, hsize};
    prof     = hb_d[1][7:6];
    rate     = hb_d[1][5:2];
    ch       = {hb_d[1][0], hb_d[2][7:6]};
    if (ch == 3'd0) begin
      ch = 3'd2;
    end
    info     = {prof, rate, ch};
    obj_type = {1'b0, prof} + 3'd1;
  end

  // One-pass decode of the accepted beat
  always_comb begin
    phase_d  = phase_q;
    count_d  = count_q;
    rem_d    = rem_q;
    serr_d   = serr_q;
    ivalid_d = ivalid_q;
    sinfo_d  = sinfo_q;
    ftime_d  = ftime_q;
    hunt     = 1'b0;

    out_valid_d = out_valid_q & out_stall_i;
    res_d       = res_q;

    if (in_fire) begin
      out_valid_d = 1'b0;
      res_d       = '0;
      res_d.track = track_q;

      if (kind_i == adts_pkg::KIND_FLUSH) begin
        // flush: close an open payload and drop stream state
        if (phase_q == adts_pkg::PH_PAYLOAD && rem_q != 13'd0) begin
          out_valid_d = 1'b1;
          res_d.kind  = adts_pkg::OUT_TRUNC;
        end
        phase_d  = adts_pkg::PH_HUNT;
        count_d  = 4'd0;
        rem_d    = 13'd0;
        serr_d   = 1'b0;
        ivalid_d = 1'b0;
        sinfo_d  = 9'd0;
      end else begin
        unique case (phase_q)
          adts_pkg::PH_SYNC2: begin
            if (data_byte_i[7:4] == adts_pkg::SYNC_NIBBLE) begin
              count_d = 4'd2;
              serr_d  = 1'b0;
              phase_d = adts_pkg::PH_HEADER;
            end else begin
              phase_d = adts_pkg::PH_HUNT;
              if (!serr_q) begin
                serr_d      = 1'b1;
                out_valid_d = 1'b1;
                res_d.kind  = adts_pkg::OUT_SYNC_LOST;
              end
            end
          end

          adts_pkg::PH_HEADER: begin
            count_d = count_q + 4'd1;
            if (count_d >= hsize) begin
              count_d     = 4'd0;
              out_valid_d = 1'b1;
              if (flen < {9'd0, hsize}) begin
                phase_d    = adts_pkg::PH_HUNT;
                rem_d      = 13'd0;
                res_d.kind = adts_pkg::OUT_LEN_ERR;
              end else begin
                rem_d                = plen;
                sinfo_d              = info;
                ivalid_d             = 1'b1;
                res_d.kind           = adts_pkg::OUT_HEADER;
                res_d.last           = (plen == 13'd0);
                res_d.profile        = prof;
                res_d.rate_index     = rate;
                res_d.channels       = ch;
                res_d.config_changed = !ivalid_q || (sinfo_q != info);
                res_d.audio_config   = {2'b00, obj_type, rate, 1'b0, ch, 3'b000};
                res_d.timestamp_ms   = ftime_q;
                res_d.payload_length = plen;
                ftime_d = ftime_q + {24'd0, adts_pkg::frame_step_ms(rate)};
                phase_d = (plen == 13'd0) ? adts_pkg::PH_HUNT : adts_pkg::PH_PAYLOAD;
              end
            end
          end

          adts_pkg::PH_PAYLOAD: begin
            if (rem_q != 13'd0) begin
              out_valid_d        = 1'b1;
              res_d.kind         = adts_pkg::OUT_PAYLOAD;
              res_d.payload_byte = data_byte_i;
              rem_d              = rem_q - 13'd1;
              if (rem_d == 13'd0) begin
                res_d.last = 1'b1;
                phase_d    = adts_pkg::PH_HUNT;
              end
            end else begin
              hunt = 1'b1;
            end
          end

          default: begin
            hunt = 1'b1;
          end
        endcase

        // hunting for the first sync byte
        if (hunt) begin
          if (data_byte_i == adts_pkg::SYNC_BYTE) begin
            phase_d = adts_pkg::PH_SYNC2;
          end else begin
            phase_d = adts_pkg::PH_HUNT;
            if (!serr_q) begin
              serr_d      = 1'b1;
              out_valid_d = 1'b1;
              res_d.kind  = adts_pkg::OUT_SYNC_LOST;
            end
          end
        end
      end
    end

    // start time write reloads the running frame time
    if (cfg_valid_i && cfg_ready_o && cfg_index_i == adts_pkg::CFG_START_TIME) begin
      ftime_d = cfg_data_i;
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= adts_pkg::PH_HUNT;
      count_q     <= 4'd0;
      rem_q       <= 13'd0;
      serr_q      <= 1'b0;
      ivalid_q    <= 1'b0;
      sinfo_q     <= 9'd0;
      ftime_q     <= 32'd0;
      track_q     <= 8'd0;
      out_valid_q <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      count_q     <= count_d;
      rem_q       <= rem_d;
      serr_q      <= serr_d;
      ivalid_q    <= ivalid_d;
      sinfo_q     <= sinfo_d;
      ftime_q     <= ftime_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i && cfg_ready_o && cfg_index_i == adts_pkg::CFG_TRACK) begin
        track_q <= cfg_data_i[7:0];
      end
    end
  end

  // Payload registers: header bytes and result record
  always_ff @(posedge clk_i) begin
    if (in_fire && kind_i == adts_pkg::KIND_BYTE) begin
      hb_q <= hb_d;
    end
    res_q <= res_d;
  end

  // Port drive
  assign out_valid_o      = out_valid_q;
  assign out_kind_o       = res_q.kind;
  assign payload_byte_o   = res_q.payload_byte;
  assign last_o           = res_q.last;
  assign profile_o        = res_q.profile;
  assign rate_index_o     = res_q.rate_index;
  assign channels_o       = res_q.channels;
  assign config_changed_o = res_q.config_changed;
  assign audio_config_o   = res_q.audio_config;
  assign timestamp_ms_o   = res_q.timestamp_ms;
  assign payload_length_o = res_q.payload_length;
  assign track_o          = res_q.track;

  // Checks
  `ADTS_ASSERT(a_payload_rem_nonzero, (phase_q == adts_pkg::PH_PAYLOAD) |-> (rem_q != 13'd0), "payload phase with nothing remaining")
  `ADTS_ASSERT(a_hdr_last_empty, (out_valid_q && res_q.kind == adts_pkg::OUT_HEADER) |-> (res_q.last == (res_q.payload_length == 13'd0)), "header last flag disagrees with payload length")
  `ADTS_ASSERT(a_last_byte_hunts, (in_fire && kind_i == adts_pkg::KIND_BYTE && phase_q == adts_pkg::PH_PAYLOAD && rem_q == 13'd1) |=> (phase_q == adts_pkg::PH_HUNT && out_valid_q && res_q.last), "last payload byte did not close the frame")
  `ADTS_ASSERT(a_sync_lost_flagged, (out_valid_q && res_q.kind == adts_pkg::OUT_SYNC_LOST) |-> serr_q, "sync lost reported without the error flag set")
  `ADTS_ASSERT_ALWAYS(a_count_range, count_q <= adts_pkg::HDR_SIZE_CRC, "header byte count out of range")

endmodule
